@@ src/rtcs_pkg.sv @@
`timescale 1ns / 1ps

package rtcs_pkg;

  localparam int unsigned RecW     = 16;
  localparam int unsigned SptW     = 8;
  localparam int unsigned SidesW   = 2;
  localparam int unsigned CylW     = 9;
  localparam int unsigned CountW   = 7;
  localparam int unsigned OffsetW  = 6;
  localparam int unsigned DivCntW  = 4;
  localparam logic [CylW-1:0] DefaultSpt = 9'd9;

  typedef enum logic {
    CFG_SECTORS_PER_TRACK = 1'b0,
    CFG_SIDE_COUNT        = 1'b1
  } rtcs_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } rtcs_state_e;

  typedef struct packed {
    logic [RecW-1:0]   start_record;
    logic [CountW-1:0] record_count;
    logic              unaligned_buffer;
  } rtcs_req_t;

  typedef struct packed {
    logic [RecW-1:0]    track_number;
    logic               side_select;
    logic [SptW-1:0]    first_sector;
    logic [CountW-1:0]  chunk_length;
    logic [OffsetW-1:0] buffer_offset;
    logic               last_chunk;
  } rtcs_rsp_t;

endpackage

@@ src/rtcs_div.sv @@
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle.
module rtcs_div import rtcs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RecW-1:0] dividend_i,
  input  logic [CylW-1:0] divisor_i,
  output logic            done_o,
  output logic [RecW-1:0] quotient_o,
  output logic [CylW-1:0] remainder_o
);

  logic [CylW-1:0]    rem_q, rem_d;
  logic [RecW-1:0]    quo_q, quo_d;
  logic [CylW-1:0]    div_q, div_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [CylW:0]      trial;
  logic [CylW:0]      diff;
  logic               fits;

  assign trial = {rem_q, quo_q[RecW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? diff[CylW-1:0] : trial[CylW-1:0];
      quo_d = {quo_q[RecW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ src/record_to_track_chunk_splitter_unit.sv @@
`timescale 1ns / 1ps

// Splits one disk request into per-track transfers. A request is taken when start_i is high
// and busy_o is low; it then runs through the serial divider that finds the track and the
// position within it, the quotient and remainder are loaded, and the block then emits one
// transfer per cycle, staying busy until the last one. Each transfer is shown on result_o
// for exactly one cycle with valid_o high; the receiver cannot stall, so it must take every
// transaction as it comes. A request with a zero count gives no transfers and frees the
// block at once.
module record_to_track_chunk_splitter_unit import rtcs_pkg::*; #(
  parameter int unsigned MAX_SECTORS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [SptW-1:0] cfg_data_i,
  input  logic            start_i,
  input  rtcs_req_t       req_i,
  output logic            busy_o,
  output logic            valid_o,
  output rtcs_rsp_t       result_o
);

  logic [SptW-1:0]   spt_cfg_q;
  logic [SidesW-1:0] sides_cfg_q;

  rtcs_state_e state_q, state_d;

  logic [CylW-1:0]   cyl_w;
  logic [CylW-1:0]   spt_w;
  logic [CountW-1:0] count_sat;
  logic              accept;
  logic              div_start;
  logic              div_done;
  logic [RecW-1:0]   div_quo;
  logic [CylW-1:0]   div_rem;

  logic [SptW-1:0]   spt_q;
  logic [CylW-1:0]   cyl_q;
  logic [RecW-1:0]   rec_q, rec_d;
  logic [RecW-1:0]   track_q, track_d;
  logic [CylW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] left_q, left_d;
  logic [CountW-1:0] done_q, done_d;
  logic              odd_q;

  logic              emit;
  logic              load_div;
  logic              side;
  logic [CylW-1:0]   sec_full;
  logic [SptW-1:0]   sec;
  logic [SptW-1:0]   room;
  logic [CountW-1:0] len;
  logic [RecW:0]     rec_sum;
  logic [CylW-1:0]   pos_sum;

  logic      valid_q;
  rtcs_rsp_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_cfg_q   <= '0;
      sides_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SECTORS_PER_TRACK: spt_cfg_q   <= cfg_data_i;
        CFG_SIDE_COUNT:        sides_cfg_q <= cfg_data_i[SidesW-1:0];
        default:               spt_cfg_q   <= spt_cfg_q;
      endcase
    end
  end

  // Cylinder size, with the nine-sector single-sided fallback for an empty geometry.
  always_comb begin
    case (sides_cfg_q)
      2'd0:    cyl_w = '0;
      2'd1:    cyl_w = {1'b0, spt_cfg_q};
      default: cyl_w = {spt_cfg_q, 1'b0};
    endcase
    spt_w = {1'b0, spt_cfg_q};
    if (cyl_w == '0) begin
      cyl_w = DefaultSpt;
      spt_w = DefaultSpt;
    end
  end

  always_comb begin
    if (int'(req_i.record_count) > int'(MAX_SECTORS)) begin
      count_sat = CountW'(MAX_SECTORS);
    end else begin
      count_sat = req_i.record_count;
    end
  end

  assign accept    = start_i && (state_q == ST_IDLE);
  assign div_start = accept && (count_sat != '0);

  rtcs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (req_i.start_record),
    .divisor_i   (cyl_w),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (div_start) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (left_q == len) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    load_div = 1'b0;
    busy_o   = 1'b1;
    case (state_q)
      ST_IDLE:   busy_o   = 1'b0;
      ST_DIVIDE: load_div = div_done;
      ST_EMIT:   emit     = 1'b1;
      default:   busy_o   = 1'b1;
    endcase
  end

  // Position within the cylinder split into head and sector, plus the next chunk's length and sums.
  always_comb begin
    side     = pos_q >= {1'b0, spt_q};
    sec_full = side ? (pos_q - {1'b0, spt_q}) : pos_q;
    sec      = sec_full[SptW-1:0];
    room     = spt_q - sec;
    if (odd_q) begin
      len = CountW'(1);
    end else if (room < {1'b0, left_q}) begin
      len = room[CountW-1:0];
    end else begin
      len = left_q;
    end
    rec_sum = {1'b0, rec_q} + (RecW+1)'(len);
    pos_sum = pos_q + CylW'(len);
  end

  always_comb begin
    rec_d   = rec_q;
    track_d = track_q;
    pos_d   = pos_q;
    left_d  = left_q;
    done_d  = done_q;
    if (accept) begin
      rec_d  = req_i.start_record;
      left_d = count_sat;
      done_d = '0;
    end else if (load_div) begin
      track_d = div_quo;
      pos_d   = div_rem;
    end else if (emit) begin
      rec_d  = rec_sum[RecW-1:0];
      left_d = left_q - len;
      done_d = done_q + len;
      if (rec_sum[RecW]) begin
        // The record number wraps around past zero; the wrapped record is treated as lying in the first cylinder.
        track_d = '0;
        pos_d   = CylW'(rec_sum[RecW-1:0]);
      end else if (pos_sum == cyl_q) begin
        track_d = track_q + 1'b1;
        pos_d   = '0;
      end else begin
        pos_d = pos_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q   <= rec_d;
    track_q <= track_d;
    pos_q   <= pos_d;
    left_q  <= left_d;
    done_q  <= done_d;
    if (accept) begin
      spt_q <= spt_w[SptW-1:0];
      cyl_q <= cyl_w;
      odd_q <= req_i.unaligned_buffer;
    end
    if (emit) begin
      result_q.track_number  <= track_q;
      result_q.side_select   <= side;
      result_q.first_sector  <= sec + 1'b1;
      result_q.chunk_length  <= len;
      result_q.buffer_offset <= done_q[OffsetW-1:0];
      result_q.last_chunk    <= (left_q == len);
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
